FILE: hw/rtl/lvd_pkg.sv
// shared types and constants of the light baseline vote detector
// no dependencies; imported by every module of the block
`default_nettype none

package lvd_pkg;

   // fixed lane count and sample width of the stream words
   localparam int CHANNELS      = 4;
   localparam int SAMPLE_BITS   = 12;
   localparam int THRESH_BITS   = 12;
   localparam int ACTIVE_BITS   = 3;
   localparam int VOTE_BITS     = 3;

   // stream word layout
   localparam int REQ_DATA_BITS = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_USED_BITS = CHANNELS * SAMPLE_BITS + CHANNELS + VOTE_BITS + 1;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;

   // register file port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 12;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE_CHANNELS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD_DELTA = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VOTE_REQUIRED   = 2'd2;

   // window mode codes
   localparam logic OP_DETECT    = 1'b0;
   localparam logic OP_CALIBRATE = 1'b1;

   // control from the top level to every lane
   typedef struct packed {
      logic                   acc;        // word accepted this cycle
      logic                   last;       // it closes the window
      logic                   load_prod;  // window total moves to multiplier stage
      logic                   load_avg;   // product moves to compare stage
      logic                   mode_avg;   // mode of the window in the compare stage
      logic [THRESH_BITS-1:0] threshold;
   } lvd_ctrl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lvd_lane.sv
// one channel lane: window accumulator, reciprocal divide and baseline compare
// depends on lvd_pkg
`default_nettype none

module lvd_lane
   import lvd_pkg::*;
#(
   parameter int AVERAGE_SAMPLES = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lvd_ctrl_type           ctrl,
   input  wire logic                   lane_on,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   output logic      [SAMPLE_BITS-1:0] average,
   output logic                        flag
);

   localparam int LOG_N     = $clog2(AVERAGE_SAMPLES);
   localparam int SUM_BITS  = SAMPLE_BITS + LOG_N;
   localparam int SHIFT     = SUM_BITS + LOG_N;
   localparam int RCP_BITS  = SUM_BITS + 1;
   localparam int PROD_BITS = SUM_BITS + RCP_BITS;
   // ceil(2^SHIFT / N): exact floor quotient for every sum below 2^SUM_BITS
   localparam longint unsigned RCP =
      ((longint'(1) << SHIFT) + longint'(AVERAGE_SAMPLES) - 1) / longint'(AVERAGE_SAMPLES);
   localparam logic [RCP_BITS-1:0] RCP_V = RCP_BITS'(RCP);

   logic [SUM_BITS-1:0]    sum_ff, sum_in, total;
   logic [SUM_BITS-1:0]    tot_ff;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0] quot, delta;
   logic [SAMPLE_BITS-1:0] base_ff, base_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic                   flag_ff, flag_in;

   assign total   = sum_ff + SUM_BITS'(sample);
   assign prod_in = PROD_BITS'(tot_ff) * PROD_BITS'(RCP_V);
   assign quot    = prod_ff[SHIFT +: SAMPLE_BITS];
   assign delta   = (quot >= base_ff) ? (quot - base_ff) : (base_ff - quot);

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.acc) begin
         sum_in = ctrl.last ? '0 : total;
      end
   end

   always_comb begin
      avg_in  = lane_on ? quot : '0;
      flag_in = lane_on && (ctrl.mode_avg == OP_DETECT) && (delta >= ctrl.threshold);
      base_in = base_ff;
      if (lane_on && (ctrl.mode_avg == OP_CALIBRATE)) begin
         base_in = quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         base_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         if (ctrl.load_avg) begin
            base_ff <= base_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc && ctrl.last) begin
         tot_ff <= total;
      end
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load_avg) begin
         avg_ff  <= avg_in;
         flag_ff <= flag_in;
      end
   end

   assign average = avg_ff;
   assign flag    = flag_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lvd_merge.sv
// merge stage: counts lane flags, applies the vote and holds the result word
// depends on lvd_pkg
`default_nettype none

module lvd_merge
   import lvd_pkg::*;
(
   input  wire logic                                 clock,
   input  wire logic                                 load,
   input  wire logic                                 mode,
   input  wire logic [VOTE_BITS-1:0]                 vote_required,
   input  wire logic [CHANNELS-1:0][SAMPLE_BITS-1:0] lane_avg,
   input  wire logic [CHANNELS-1:0]                  lane_flag,
   output logic      [RSP_DATA_BITS-1:0]             data,
   output logic                                      kind
);

   logic [VOTE_BITS-1:0]     votes;
   logic                     light;
   logic [RSP_DATA_BITS-1:0] data_ff, data_in;
   logic                     kind_ff;

   always_comb begin
      votes = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         votes = votes + VOTE_BITS'(lane_flag[i]);
      end
   end

   assign light   = (mode == OP_DETECT) && (votes >= vote_required);
   assign data_in = RSP_DATA_BITS'({light, votes, lane_flag, lane_avg});

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         kind_ff <= mode;
      end
   end

   assign data = data_ff;
   assign kind = kind_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/light_baseline_vote_detector.sv
// top level of the light baseline vote detector: register file, window control,
// lane array and merge stage; depends on lvd_pkg, lvd_lane and lvd_merge
//
// usage
// - req_ words carry one sample per channel (tdata) and the window opcode (tuser);
//   every AVERAGE_SAMPLES accepted words form a window, the opcode of its first
//   word picks detect or calibrate
// - one rsp_ word leaves per window: floor averages, flag mask, vote count and
//   the light decision, with tuser marking a calibration window
// - once the window's last word is accepted, its totals pass through the total,
//   product, compare and merge registers before the result word is offered
// - throughput: one word per cycle; the lane accumulators take a new word every
//   cycle and only the window-closing word waits for room in the result pipeline
// - when the receiver stalls, words that do not close a window are still taken;
//   up to four finished windows sit in the pipeline before req_tready drops
// - reset clears the window count, the sums, the baselines and all valid flags,
//   and loads the register defaults (4 channels, threshold 200, vote 2)
// - registers are written through csr_ with no wait; write them while idle
`default_nettype none

module light_baseline_vote_detector
   import lvd_pkg::*;
#(
   parameter int AVERAGE_SAMPLES = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input stream
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,   // sample_0 .. sample_3, 12 bits each
   input  wire logic                     req_tuser,   // opcode
   // result stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,   // average_0 .. average_3,
                                                      // detected_mask, vote_count,
                                                      // light_detected
   output logic                          rsp_tuser,   // was_calibration
   // register write port
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CNT_BITS = (AVERAGE_SAMPLES > 1) ? $clog2(AVERAGE_SAMPLES) : 1;
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(AVERAGE_SAMPLES - 1);

   // register file
   logic [ACTIVE_BITS-1:0] active_ff;
   logic [THRESH_BITS-1:0] thresh_ff;
   logic [VOTE_BITS-1:0]   vote_ff;

   // window control
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   mode_ff, mode_in;
   logic                   win_first, win_last, win_mode;
   logic                   acc;

   // result pipeline: total, product, compare, output word
   logic                   v1_ff, v2_ff, v3_ff, out_vld_ff;
   logic                   m1_ff, m2_ff, m3_ff;
   logic                   rdy1, rdy2, rdy3, rdy4;
   logic                   en1, en2, en3, en4;

   lvd_ctrl_type                     ctrl;
   logic [CHANNELS-1:0]              lane_on;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] lane_avg;
   logic [CHANNELS-1:0]              lane_flag;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_BITS'(4);
         thresh_ff <= THRESH_BITS'(200);
         vote_ff   <= VOTE_BITS'(2);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ACTIVE_CHANNELS: active_ff <= csr_wdata[ACTIVE_BITS-1:0];
            CSR_THRESHOLD_DELTA: thresh_ff <= csr_wdata[THRESH_BITS-1:0];
            CSR_VOTE_REQUIRED:   vote_ff   <= csr_wdata[VOTE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // back-pressure chain, each stage frees when the next can take its word
   assign rdy4 = !out_vld_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign win_first  = (cnt_ff == '0);
   assign win_last   = (cnt_ff == CNT_LAST);
   // a window-closing word needs room in the total stage
   assign req_tready = !win_last || rdy1;
   assign acc        = req_tvalid && req_tready;
   assign win_mode   = win_first ? req_tuser : mode_ff;

   assign en1 = acc && win_last;
   assign en2 = v1_ff && rdy2;
   assign en3 = v2_ff && rdy3;
   assign en4 = v3_ff && rdy4;

   always_comb begin
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      if (acc) begin
         cnt_in  = win_last ? '0 : cnt_ff + CNT_BITS'(1);
         mode_in = win_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         mode_ff    <= OP_DETECT;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
         if (en1) begin
            v1_ff <= 1'b1;
         end else if (en2) begin
            v1_ff <= 1'b0;
         end
         if (en2) begin
            v2_ff <= 1'b1;
         end else if (en3) begin
            v2_ff <= 1'b0;
         end
         if (en3) begin
            v3_ff <= 1'b1;
         end else if (en4) begin
            v3_ff <= 1'b0;
         end
         if (en4) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // window mode travels with its token
   always_ff @(posedge clock) begin
      if (en1) begin
         m1_ff <= win_mode;
      end
      if (en2) begin
         m2_ff <= m1_ff;
      end
      if (en3) begin
         m3_ff <= m2_ff;
      end
   end

   assign ctrl.acc       = acc;
   assign ctrl.last      = win_last;
   assign ctrl.load_prod = en2;
   assign ctrl.load_avg  = en3;
   assign ctrl.mode_avg  = m2_ff;
   assign ctrl.threshold = thresh_ff;

   // lanes at or above the active count report zero; counts above the
   // lane number simply switch every lane on
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      assign lane_on[i] = (ACTIVE_BITS'(i) < active_ff);

      lvd_lane #(
         .AVERAGE_SAMPLES (AVERAGE_SAMPLES)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .lane_on (lane_on[i]),
         .sample  (req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]),
         .average (lane_avg[i]),
         .flag    (lane_flag[i])
      );
   end

   lvd_merge u_merge (
      .clock         (clock),
      .load          (en4),
      .mode          (m3_ff),
      .vote_required (vote_ff),
      .lane_avg      (lane_avg),
      .lane_flag     (lane_flag),
      .data          (rsp_tdata),
      .kind          (rsp_tuser)
   );

   assign rsp_tvalid = out_vld_ff;

   // a new result word only comes from a filled compare stage
   a_out_from_stage3: assert property (@(posedge clock) disable iff (reset)
      ($rose(out_vld_ff) |-> $past(v3_ff)))
      else $error("result word without compare stage token");

   // the total stage only fills when a window closes
   a_stage1_fill: assert property (@(posedge clock) disable iff (reset)
      ((v1_ff && !$past(v1_ff)) |-> $past(acc && win_last)))
      else $error("total stage filled outside a window close");

   // input back-pressure only for a closing word with a full total stage
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      (!req_tready |-> (win_last && v1_ff && !rdy2)))
      else $error("input stalled without cause");

   // calibration windows report no flags, votes or light
   a_calib_quiet: assert property (@(posedge clock) disable iff (reset)
      ((rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[RSP_USED_BITS-1:CHANNELS*SAMPLE_BITS] == '0)))
      else $error("calibration result carries detection bits");

endmodule

`default_nettype wire
